### rtl/cubic_bezier_point_generator_macros.svh
// Assertion macros used by the cubic Bezier point generator back end (cbpg_back).
// Define NO_ASSERTIONS to compile every assertion away; no other dependencies.
`ifndef CUBIC_BEZIER_POINT_GENERATOR_MACROS_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge out of reset.
`define CBPG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cbpg assertion failed");
// A condition that must be followed by another in the next cycle.
`define CBPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbpg next-cycle assertion failed");
`else
`define CBPG_ASSERT(lbl, clk, rst_n, prop)
`define CBPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/cbpg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the cubic Bezier point generator.
// No dependencies; every other RTL module imports this package.
package cbpg_pkg;

  // Default number of interior points per curve.
  localparam int STEPS_DEFAULT = 30;

  // Fixed-point formats.
  localparam int COORD_W   = 16;  // Q12.4 coordinate
  localparam int FRAC_BITS = 40;  // extra fraction bits of the difference registers
  localparam int ACC_W     = 64;  // difference register width
  localparam int OPW       = 20;  // width of the control point combinations
  localparam int COEF_W    = 41;  // width of the Q0.40 coefficients
  localparam int CHUNK_W   = 21;  // coefficient slice fed to the multiplier
  localparam int PROD_W    = OPW + CHUNK_W + 1;

  // Stream widths.
  localparam int IN_W  = 8 * COORD_W;
  localparam int OUT_W = 2 * COORD_W;

  // Curves buffered between setup and point generation.
  localparam int QUEUE_DEPTH = 2;

  // Front end sequencer states.
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CALC,
    FR_FLUSH,
    FR_PUSH
  } cbpg_front_state_t;

  // Products formed during setup, in issue order.
  typedef enum logic [2:0] {
    TERM_T2C5,  // t2 * 6h^3, into the third and second differences
    TERM_T1C4,  // t1 * 6h^2, into the second difference
    TERM_DC1,   // (q2 - q1) * 3h, into the first difference
    TERM_T1C2,  // t1 * 3h^2, into the first difference
    TERM_T2C3   // t2 * h^3, into the first difference
  } cbpg_term_t;

  // One curve after setup: anchors and initial differences, indexed by axis.
  typedef struct packed {
    logic [1:0][COORD_W-1:0] anc_a;
    logic [1:0][COORD_W-1:0] anc_b;
    logic [1:0][ACC_W-1:0]   d1;
    logic [1:0][ACC_W-1:0]   d2;
    logic [1:0][ACC_W-1:0]   d3;
  } cbpg_curve_t;

  // Takes the integer part of a biased difference value and clamps it to Q12.4.
  function automatic logic [COORD_W-1:0] sat_coord(input logic [ACC_W-1:0] f);
    logic [ACC_W-FRAC_BITS-1:0]           r;
    logic [ACC_W-FRAC_BITS-COORD_W:0]     hi;
    r  = f[ACC_W-1:FRAC_BITS];
    hi = r[ACC_W-FRAC_BITS-1:COORD_W-1];
    if ((&hi) || !(|hi)) begin
      return r[COORD_W-1:0];
    end else if (r[ACC_W-FRAC_BITS-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/cbpg_front.sv
`timescale 1ns / 1ps
// Setup front end: accepts a curve, forms the control point combinations and
// computes the initial forward differences on one shared multiplier. Uses cbpg_pkg.
module cbpg_front import cbpg_pkg::*; #(
  parameter int STEPS = STEPS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  output logic              push_valid,
  input  logic              push_ready,
  output cbpg_curve_t       push_curve
);

  // Coefficients in Q0.40, rounded to nearest with ties up.
  localparam logic [63:0] N1 = 64'(STEPS + 1);
  localparam logic [63:0] N2 = N1 * N1;
  localparam logic [63:0] N3 = N2 * N1;
  localparam logic [COEF_W-1:0] C1 = COEF_W'(((64'd3 << FRAC_BITS) + N1 / 2) / N1);
  localparam logic [COEF_W-1:0] C2 = COEF_W'(((64'd3 << FRAC_BITS) + N2 / 2) / N2);
  localparam logic [COEF_W-1:0] C4 = COEF_W'(((64'd6 << FRAC_BITS) + N2 / 2) / N2);
  localparam logic [COEF_W-1:0] C5 = COEF_W'(((64'd6 << FRAC_BITS) + N3 / 2) / N3);
  localparam logic [COEF_W-1:0] C3 = COEF_W'(((64'd1 << FRAC_BITS) + N3 / 2) / N3);

  cbpg_front_state_t state_r, state_nxt;

  logic                     accept;
  logic                     last_op;

  // Control point combinations, per axis.
  logic signed [OPW-1:0]    q1_w [2];
  logic signed [OPW-1:0]    q2_w [2];
  logic signed [OPW-1:0]    q3_w [2];
  logic signed [OPW-1:0]    q4_w [2];
  logic signed [OPW-1:0]    d_w  [2];
  logic signed [OPW-1:0]    t1_w [2];
  logic signed [OPW-1:0]    t2_w [2];
  logic signed [OPW-1:0]    d_r  [2];
  logic signed [OPW-1:0]    t1_r [2];
  logic signed [OPW-1:0]    t2_r [2];
  logic [1:0][COORD_W-1:0]  anc_a_r;
  logic [1:0][COORD_W-1:0]  anc_b_r;

  // Issue sequencer.
  logic                     axis_r;
  cbpg_term_t               term_r;
  logic                     chunk_r;
  cbpg_term_t               term_next;

  // Multiplier stage.
  logic signed [OPW-1:0]    op_sel;
  logic [COEF_W-1:0]        coef_full;
  logic [CHUNK_W-1:0]       coef_chunk;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic                     p1_v_r;
  logic                     p1_axis_r;
  cbpg_term_t               p1_term_r;
  logic                     p1_chunk_r;

  // Accumulators.
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_d1_r [2];
  logic signed [ACC_W-1:0]  acc_d2_r [2];
  logic signed [ACC_W-1:0]  acc_d3_r [2];

  assign accept = in_tvalid && in_tready;

  // Unpack the beat and form q2-q1, t1 and t2 for both axes.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      q1_w[a] = OPW'($signed(in_tdata[COORD_W*a +: COORD_W]));
      q2_w[a] = OPW'($signed(in_tdata[COORD_W*(2+a) +: COORD_W]));
      q3_w[a] = OPW'($signed(in_tdata[COORD_W*(4+a) +: COORD_W]));
      q4_w[a] = OPW'($signed(in_tdata[COORD_W*(6+a) +: COORD_W]));
      d_w[a]  = q2_w[a] - q1_w[a];
      t1_w[a] = q1_w[a] - (q2_w[a] <<< 1) + q3_w[a];
      t2_w[a] = (q2_w[a] - q3_w[a]) + ((q2_w[a] - q3_w[a]) <<< 1) - q1_w[a] + q4_w[a];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < 2; a++) begin
        d_r[a]     <= d_w[a];
        t1_r[a]    <= t1_w[a];
        t2_r[a]    <= t2_w[a];
        anc_a_r[a] <= in_tdata[COORD_W*a +: COORD_W];
        anc_b_r[a] <= in_tdata[COORD_W*(6+a) +: COORD_W];
      end
    end
  end

  // Order in which products are issued for one axis.
  always_comb begin
    unique case (term_r)
      TERM_T2C5: term_next = TERM_T1C4;
      TERM_T1C4: term_next = TERM_DC1;
      TERM_DC1:  term_next = TERM_T1C2;
      TERM_T1C2: term_next = TERM_T2C3;
      TERM_T2C3: term_next = TERM_T2C5;
      default:   term_next = TERM_T2C5;
    endcase
  end

  assign last_op = axis_r && (term_r == TERM_T2C3) && chunk_r;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    push_valid = 1'b0;
    unique case (state_r)
      FR_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = FR_CALC;
        end
      end
      FR_CALC: begin
        if (last_op) begin
          state_nxt = FR_FLUSH;
        end
      end
      FR_FLUSH: begin
        state_nxt = FR_PUSH;
      end
      FR_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  // Walk axis, term and coefficient half while in the calculation state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r  <= 1'b0;
      term_r  <= TERM_T2C5;
      chunk_r <= 1'b0;
    end else if (accept) begin
      axis_r  <= 1'b0;
      term_r  <= TERM_T2C5;
      chunk_r <= 1'b0;
    end else if (state_r == FR_CALC) begin
      chunk_r <= ~chunk_r;
      if (chunk_r) begin
        term_r <= term_next;
        if (term_r == TERM_T2C3) begin
          axis_r <= ~axis_r;
        end
      end
    end
  end

  // Operand and coefficient half for the product being issued.
  always_comb begin
    case (term_r)
      TERM_T2C5: begin
        op_sel    = t2_r[axis_r];
        coef_full = C5;
      end
      TERM_T1C4: begin
        op_sel    = t1_r[axis_r];
        coef_full = C4;
      end
      TERM_DC1: begin
        op_sel    = d_r[axis_r];
        coef_full = C1;
      end
      TERM_T1C2: begin
        op_sel    = t1_r[axis_r];
        coef_full = C2;
      end
      default: begin
        op_sel    = t2_r[axis_r];
        coef_full = C3;
      end
    endcase
    coef_chunk = chunk_r ? CHUNK_W'(coef_full[COEF_W-1:CHUNK_W])
                         : coef_full[CHUNK_W-1:0];
    prod_nxt   = op_sel * $signed({1'b0, coef_chunk});
  end

  // Product register and its tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= (state_r == FR_CALC);
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    p1_axis_r  <= axis_r;
    p1_term_r  <= term_r;
    p1_chunk_r <= chunk_r;
  end

  // Align the partial product to its coefficient half.
  assign prod_ext = ACC_W'(prod_r);
  assign addend   = p1_chunk_r ? (prod_ext <<< CHUNK_W) : prod_ext;

  // Accumulate the partial products into the difference sums.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < 2; a++) begin
        acc_d1_r[a] <= '0;
        acc_d2_r[a] <= '0;
        acc_d3_r[a] <= '0;
      end
    end else if (p1_v_r) begin
      case (p1_term_r)
        TERM_T2C5: begin
          acc_d3_r[p1_axis_r] <= acc_d3_r[p1_axis_r] + addend;
          acc_d2_r[p1_axis_r] <= acc_d2_r[p1_axis_r] + addend;
        end
        TERM_T1C4: begin
          acc_d2_r[p1_axis_r] <= acc_d2_r[p1_axis_r] + addend;
        end
        default: begin
          acc_d1_r[p1_axis_r] <= acc_d1_r[p1_axis_r] + addend;
        end
      endcase
    end
  end

  // Finished curve handed to the queue.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      push_curve.anc_a[a] = anc_a_r[a];
      push_curve.anc_b[a] = anc_b_r[a];
      push_curve.d1[a]    = acc_d1_r[a];
      push_curve.d2[a]    = acc_d2_r[a];
      push_curve.d3[a]    = acc_d3_r[a];
    end
  end

endmodule

### rtl/cbpg_queue.sv
`timescale 1ns / 1ps
// Short queue of set-up curves between the front end and the point generator.
// Uses cbpg_pkg for the curve type and the depth.
module cbpg_queue import cbpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  cbpg_curve_t push_curve,
  output logic        pop_valid,
  input  logic        pop_ready,
  output cbpg_curve_t pop_curve
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cbpg_curve_t      slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_curve  = slot_r[rd_ptr_r];

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_curve;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/cbpg_back.sv
`timescale 1ns / 1ps
// Point generator back end: steps the forward differences of one curve per
// point and drives the registered result stream. Uses cbpg_pkg and the macros.
`include "cubic_bezier_point_generator_macros.svh"
module cbpg_back import cbpg_pkg::*; #(
  parameter int STEPS = STEPS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  cbpg_curve_t      pop_curve,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int             IDX_W    = $clog2(STEPS + 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS + 1);

  logic                     active_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     step;
  logic                     last_idx;
  logic                     pop;
  logic [1:0][COORD_W-1:0]  anc_a_r;
  logic [1:0][COORD_W-1:0]  anc_b_r;
  logic signed [ACC_W-1:0]  f_r    [2];
  logic signed [ACC_W-1:0]  df_r   [2];
  logic signed [ACC_W-1:0]  ddf_r  [2];
  logic signed [ACC_W-1:0]  dddf_r [2];
  logic [1:0][COORD_W-1:0]  point_w;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;
  logic                     out_last_r;

  // Advance one point whenever the output register is free or being drained.
  assign step      = active_r && (!out_valid_r || out_tready);
  assign last_idx  = (idx_r == LAST_IDX);
  assign pop       = pop_valid && (!active_r || (step && last_idx));
  assign pop_ready = pop;

  // Point sequence control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else if (pop) begin
      active_r <= 1'b1;
      idx_r    <= '0;
    end else if (step) begin
      idx_r <= idx_r + 1'b1;
      if (last_idx) begin
        active_r <= 1'b0;
      end
    end
  end

  // Difference registers; f carries a half-LSB bias so rounding is a truncation.
  always_ff @(posedge clk) begin
    if (pop) begin
      anc_a_r <= pop_curve.anc_a;
      anc_b_r <= pop_curve.anc_b;
      for (int a = 0; a < 2; a++) begin
        f_r[a]    <= {{(ACC_W-FRAC_BITS-COORD_W){pop_curve.anc_a[a][COORD_W-1]}},
                      pop_curve.anc_a[a], 1'b1, {(FRAC_BITS-1){1'b0}}};
        df_r[a]   <= pop_curve.d1[a];
        ddf_r[a]  <= pop_curve.d2[a];
        dddf_r[a] <= pop_curve.d3[a];
      end
    end else if (step) begin
      for (int a = 0; a < 2; a++) begin
        f_r[a]   <= f_r[a] + df_r[a];
        df_r[a]  <= df_r[a] + ddf_r[a];
        ddf_r[a] <= ddf_r[a] + dddf_r[a];
      end
    end
  end

  // Select the anchor copy or the rounded, clamped interior point.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (idx_r == '0) begin
        point_w[a] = anc_a_r[a];
      end else if (last_idx) begin
        point_w[a] = anc_b_r[a];
      end else begin
        point_w[a] = sat_coord(f_r[a]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= point_w;
      out_last_r <= last_idx;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A newly taken curve always starts at its first anchor.
  `CBPG_ASSERT_NEXT(a_pop_starts, clk, rst_n, pop, active_r && (idx_r == '0))
  // The point index never runs past the second anchor.
  `CBPG_ASSERT(a_idx_range, clk, rst_n, !active_r || (idx_r <= LAST_IDX))
  // Finishing a curve with nothing queued leaves the generator idle.
  `CBPG_ASSERT_NEXT(a_done_idle, clk, rst_n, step && last_idx && !pop_valid, !active_r)

endmodule

### rtl/cubic_bezier_point_generator.sv
`timescale 1ns / 1ps
// Top level of the cubic Bezier point generator: setup front end, curve queue
// and point generator back end. Uses cbpg_pkg, cbpg_front, cbpg_queue, cbpg_back.
//
//   Channel  Direction  Beat contents
//   in_*     slave      one curve: two anchors and two control points, Q12.4
//   out_*    master     one curve point, Q12.4; tlast on the second anchor
//
// Each curve yields STEPS+2 points (32 at the default) at one point per cycle while
// out_tready is high and curves are queued; the output port sets the rate.
// Setup runs on the single shared 20x22 multiplier in the front end and
// overlaps with point generation of the previous curve; the queue holds two curves.
// Reset (rst_n, synchronous) clears the control state only; no store needs clearing.
// A low out_tready freezes the back end; the front end keeps accepting until the queue fills.
module cubic_bezier_point_generator import cbpg_pkg::*; #(
  parameter int STEPS = STEPS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // anchor_a_x, anchor_a_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
  // anchor_b_x, anchor_b_y (16 bits each, lowest first)
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // point_x [15:0], point_y [31:16]
  output logic [OUT_W-1:0] out_tdata,
  // is_final
  output logic             out_tlast
);

  logic        push_valid;
  logic        push_ready;
  cbpg_curve_t push_curve;
  logic        pop_valid;
  logic        pop_ready;
  cbpg_curve_t pop_curve;

  cbpg_front #(
    .STEPS(STEPS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_curve (push_curve)
  );

  cbpg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_curve (push_curve),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_curve  (pop_curve)
  );

  cbpg_back #(
    .STEPS(STEPS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_curve  (pop_curve),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### sim/cubic_bezier_point_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bezier_point_generator: drives curves with random gaps,
// predicts every point by forward differencing, and checks each output beat in order.
// Depends on cbpg_pkg and the RTL of the block only.
module cubic_bezier_point_generator_tb;
  import cbpg_pkg::*;

  localparam int  N_STEPS     = STEPS_DEFAULT;
  localparam int  HOLD_BEAT   = 32 * 35;
  localparam int  HOLD_CYCLES = 700;
  localparam int  LIMIT       = 600000;
  localparam int  N_RANDOM    = 100;
  localparam int  TAIL_CYCLES = 120;

  // One expected curve point.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               fin;
  } curve_point_t;

  // One curve waiting to be sent, with its lead-in gap.
  typedef struct {
    logic [IN_W-1:0] data;
    int              gap;
    bit              drain;
  } curve_req_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic            out_tlast;

  curve_req_t   curve_q[$];
  curve_point_t point_q[$];
  curve_req_t   cur_req;
  bit           have_req = 0;
  int           gap_left = 0;
  int           rx_wait = 0;
  int           curves_sent = 0;
  int           points_seen = 0;
  int           fail_cnt = 0;
  int           cycle_cnt = 0;

  cubic_bezier_point_generator #(.STEPS(N_STEPS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Q0.40 coefficient k/d, rounded to nearest with ties up.
  function automatic longint fd_coef(input longint unsigned k, input longint unsigned d);
    longint unsigned num;
    num = (k << FRAC_BITS) + d / 2;
    return longint'(num / d);
  endfunction

  // Round a 40-fraction difference value to Q12.4 and clamp it.
  function automatic logic [COORD_W-1:0] round_q12_4(input longint v);
    longint r;
    r = (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[COORD_W-1:0];
  endfunction

  // Predict all points of one curve and queue them in emission order.
  task automatic queue_curve_points(input logic [IN_W-1:0] d);
    longint          p[8];
    longint          f[2], df[2], ddf[2], dddf[2];
    longint          q1, q2, q3, q4, t1, t2;
    longint          c1, c2, c3, c4, c5;
    longint unsigned n;
    curve_point_t    pt;
    n  = N_STEPS + 1;
    c1 = fd_coef(3, n);
    c2 = fd_coef(3, n * n);
    c4 = fd_coef(6, n * n);
    c5 = fd_coef(6, n * n * n);
    c3 = fd_coef(1, n * n * n);
    for (int i = 0; i < 8; i++) begin
      p[i] = longint'($signed(d[COORD_W*i +: COORD_W]));
    end
    for (int a = 0; a < 2; a++) begin
      q1 = p[a];
      q2 = p[2 + a];
      q3 = p[4 + a];
      q4 = p[6 + a];
      t1 = q1 - 2 * q2 + q3;
      t2 = (q2 - q3) * 3 - q1 + q4;
      f[a]    = q1 * (longint'(1) <<< FRAC_BITS);
      df[a]   = (q2 - q1) * c1 + t1 * c2 + t2 * c3;
      ddf[a]  = t1 * c4 + t2 * c5;
      dddf[a] = t2 * c5;
    end
    pt = '{x: p[0][COORD_W-1:0], y: p[1][COORD_W-1:0], fin: 1'b0};
    point_q.insert(point_q.size(), pt);
    for (int i = 0; i < N_STEPS; i++) begin
      for (int a = 0; a < 2; a++) begin
        f[a]   += df[a];
        df[a]  += ddf[a];
        ddf[a] += dddf[a];
      end
      pt = '{x: round_q12_4(f[0]), y: round_q12_4(f[1]), fin: 1'b0};
      point_q.insert(point_q.size(), pt);
    end
    pt = '{x: p[6][COORD_W-1:0], y: p[7][COORD_W-1:0], fin: 1'b1};
    point_q.insert(point_q.size(), pt);
  endtask

  // Pack eight coordinates into one input beat, anchor_a_x lowest.
  function automatic logic [IN_W-1:0] pack_curve(input int ax, input int ay,
                                                  input int cax, input int cay,
                                                  input int cbx, input int cby,
                                                  input int bx, input int by);
    logic [15:0] v[8];
    logic [IN_W-1:0] d;
    v = '{ax[15:0], ay[15:0], cax[15:0], cay[15:0], cbx[15:0], cby[15:0],
          bx[15:0], by[15:0]};
    for (int i = 0; i < 8; i++) begin
      d[COORD_W*i +: COORD_W] = v[i];
    end
    return d;
  endfunction

  task automatic add_curve(input logic [IN_W-1:0] d, input int gap, input bit drain);
    curve_req_t r;
    r.data  = d;
    r.gap   = gap;
    r.drain = drain;
    curve_q.insert(curve_q.size(), r);
  endtask

  // Sender: takes curves from the queue, waits out each gap, then offers the beat.
  always @(posedge clk) begin : curve_driver
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        queue_curve_points(in_tdata);
        curves_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (!have_req && curve_q.size() > 0) begin
          cur_req  = curve_q.pop_front();
          gap_left = cur_req.gap;
          have_req = 1;
        end
        if (have_req) begin
          if (cur_req.drain && point_q.size() > 0) begin
            // Hold this curve back until the previous ones are fully out.
          end else if (gap_left > 0) begin
            gap_left--;
          end else begin
            nv       = 1'b1;
            have_req = 0;
            in_tdata <= cur_req.data;
          end
        end
      end
      in_tvalid <= nv;
    end
  end

  // Receiver: checks every point beat and draws its own stall before the next one.
  always @(posedge clk) begin : point_monitor
    logic         nr;
    curve_point_t exp_pt;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      nr = out_tready;
      if (out_tvalid && out_tready) begin
        if (point_q.size() == 0) begin
          $error("unexpected point beat: x %0d y %0d last %0b",
                 $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tlast);
          fail_cnt++;
        end else begin
          exp_pt = point_q.pop_front();
          if (out_tdata[15:0] !== exp_pt.x) begin
            $error("point_x: expected %0d, got %0d", $signed(exp_pt.x),
                   $signed(out_tdata[15:0]));
            fail_cnt++;
          end
          if (out_tdata[31:16] !== exp_pt.y) begin
            $error("point_y: expected %0d, got %0d", $signed(exp_pt.y),
                   $signed(out_tdata[31:16]));
            fail_cnt++;
          end
          if (out_tlast !== exp_pt.fin) begin
            $error("is_final: expected %0b, got %0b", exp_pt.fin, out_tlast);
            fail_cnt++;
          end
        end
        points_seen++;
        if (points_seen == HOLD_BEAT) begin
          rx_wait = HOLD_CYCLES;
        end else if ((points_seen / 150) % 3 == 2) begin
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, 18);
        end
        nr = (rx_wait == 0);
      end else if (!out_tready) begin
        if (rx_wait > 1) begin
          rx_wait--;
        end else begin
          rx_wait = 0;
          nr = 1'b1;
        end
      end
      out_tready <= nr;
    end
  end

  // Stimulus, then the end of the run.
  initial begin : stimulus
    int k, gap, cx, cy;
    int v[8];
    int picks[4];
    picks = '{-32768, 32767, 0, -1};

    // Directed curves: extremes, straight lines, degenerate and tiny curves.
    add_curve(pack_curve(0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
    add_curve(pack_curve(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 3, 0);
    add_curve(pack_curve(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
              0, 0);
    add_curve(pack_curve(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768), 5, 0);
    add_curve(pack_curve(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767), 0, 0);
    add_curve(pack_curve(-32768, -32768, -10923, -10923, 10922, 10922, 32767, 32767), 1, 0);
    add_curve(pack_curve(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767), 0, 0);
    add_curve(pack_curve(32760, -32760, 32767, -32768, 32767, -32768, 32760, -32760), 7, 0);
    add_curve(pack_curve(1234, -1234, 1234, -1234, 1234, -1234, 1234, -1234), 0, 0);
    add_curve(pack_curve(0, 0, 1, 0, 0, 1, 1, 1), 2, 0);
    add_curve(pack_curve(0, 0, 0, 0, 0, 0, 1, -1), 0, 0);
    add_curve(pack_curve(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa,
                         16'haaaa, 16'h5555), 4, 0);
    // One coordinate at a time at an extreme, the rest at zero.
    for (int i = 0; i < 8; i++) begin
      v = '{0, 0, 0, 0, 0, 0, 0, 0};
      v[i] = (i % 2 == 0) ? 32767 : -32768;
      add_curve(pack_curve(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]),
                $urandom_range(0, 18), 0);
    end
    // Let the directed part drain completely before the random part.
    add_curve(pack_curve(-1, -1, 2, -2, -3, 3, 1, 1), 0, 1);

    // Random curves: mostly full range; some local, corner-valued or with controls on anchors.
    for (int i = 0; i < N_RANDOM; i++) begin
      k = $urandom_range(0, 9);
      if (k <= 5) begin
        for (int j = 0; j < 8; j++) v[j] = $signed(16'($urandom()));
      end else if (k <= 7) begin
        cx = $signed(16'($urandom()));
        cy = $signed(16'($urandom()));
        for (int j = 0; j < 8; j++) begin
          v[j] = ((j % 2 == 0) ? cx : cy) + $urandom_range(0, 64) - 32;
          if (v[j] > 32767) v[j] = 32767;
          if (v[j] < -32768) v[j] = -32768;
        end
      end else if (k == 8) begin
        for (int j = 0; j < 8; j++) v[j] = picks[$urandom_range(0, 3)];
      end else begin
        // Control points sitting on the anchors.
        for (int j = 0; j < 8; j++) v[j] = $signed(16'($urandom()));
        v[2] = v[0];
        v[3] = v[1];
        v[4] = v[6];
        v[5] = v[7];
      end
      gap = ((i / 20) % 2 == 1) ? 0 : $urandom_range(0, 18);
      add_curve(pack_curve(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]), gap,
                (i == 50) || (i == 80));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (curve_q.size() > 0 || have_req || in_tvalid) @(posedge clk);
    while (point_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (point_q.size() > 0) begin
      $error("%0d expected points never arrived", point_q.size());
      fail_cnt++;
    end
    $display("Run covered %0d curves and %0d point beats, with one %0d-cycle output hold,",
             curves_sent, points_seen, HOLD_CYCLES);
    $display("full-range, local and corner-value control points, and three drained phases.");
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    while (cycle_cnt < LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", cycle_cnt);
    $display("Verification failed");
    $finish;
  end

endmodule
